### src/ppcfc_pkg.sv
// Package for the per-peer credit flow control block.
// Holds action and kind codes, field widths and register reset values.
// No dependencies.
package ppcfc_pkg;

    localparam int KIND_W   = 3;
    localparam int AMOUNT_W = 20;
    localparam int TAG_W    = 16;
    localparam int MASK_W   = 16;
    localparam int PEER_W   = 4;
    localparam int ACT_W    = 3;
    localparam int CREDIT_W = 32;
    localparam int OVH_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_RESULTS = 16;

    localparam int DEF_MEMBERS     = 16;
    localparam int DEF_QUEUE_DEPTH = 16;

    localparam logic [AMOUNT_W-1:0] INIT_WINDOW_RST = AMOUNT_W'(128 * 1024);
    localparam logic [AMOUNT_W-1:0] ACK_THRESH_RST  = AMOUNT_W'(64 * 1024);
    localparam logic [OVH_W-1:0]    OVERHEAD_RST    = OVH_W'(128);

    localparam logic [KIND_W-1:0] KIND_SEND   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DATA   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ACK    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FAIL   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REINIT = 3'd4;

    localparam logic [ACT_W-1:0] ACT_SEND    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_QUEUED  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DROP    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DELIVER = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ACK     = 3'd4;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd5;
    localparam logic [ACT_W-1:0] ACT_DONE    = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_THRESH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OVERHEAD    = 2'd2;

    localparam logic signed [CREDIT_W-1:0] CREDIT_MAX = 32'sh7fff_ffff;
    localparam logic signed [CREDIT_W-1:0] CREDIT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [PEER_W-1:0]   peer;
        logic [TAG_W-1:0]    tag;
        logic [AMOUNT_W-1:0] amount;
        logic                last;
    } result_t;

endpackage

### src/ppcfc_sat_add.sv
// Shared saturating 32-bit signed adder used for all credit updates.
// Depends on ppcfc_pkg.
module ppcfc_sat_add
    import ppcfc_pkg::*;
(
    input  logic signed [CREDIT_W-1:0] a,
    input  logic signed [CREDIT_W:0]   b,
    output logic signed [CREDIT_W-1:0] sum
);
    logic signed [CREDIT_W+1:0] wide;

    always_comb begin
        wide = {{2{a[CREDIT_W-1]}}, a} + {b[CREDIT_W], b};
        if (wide > (CREDIT_W+2)'(CREDIT_MAX)) begin
            sum = CREDIT_MAX;
        end else if (wide < $signed({{2{1'b1}}, CREDIT_MIN})) begin
            sum = CREDIT_MIN;
        end else begin
            sum = wide[CREDIT_W-1:0];
        end
    end
endmodule

### src/per_peer_credit_flow_control.sv
// Per-peer credit flow control: top level with sequencer, credit tables and
// held-message memory. Depends on ppcfc_pkg and ppcfc_sat_add.
//
// Usage: items arrive on the s_ stream (tdata = kind, peer, amount, msg_tag,
// failed_mask). Each item produces one or more result transfers on the m_
// stream (tdata = action, out_peer, out_tag, out_amount; tlast marks the
// final result of an item). Registers are written through cfg_we/idx/data.
// Sequencing: one item at a time; the next is accepted only after the last
// result of the current one is taken. A send or an unknown kind passes exec
// and out; data passes exec, data2 and out, and data2 and out again when it
// also emits an ack; an ack passes exec and the ack check, then for each
// released message a held-message memory read and a release step through
// the shared saturating adder, each followed by out. Failure and reinit
// sweep the peer tables one peer per cycle; after reset a sweep loads the
// tables before s_tready rises. Stall: results wait in the output register
// while m_tready is low; the sequencer holds until each transfer completes.
module per_peer_credit_flow_control
    import ppcfc_pkg::*;
#(
    parameter int MEMBERS     = DEF_MEMBERS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // kind[2:0], peer[6:3], amount[26:7], msg_tag[42:27], failed_mask[58:43]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // action[2:0], out_peer[6:3], out_tag[22:7], out_amount[42:23]
    output logic [47:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [AMOUNT_W-1:0]  cfg_data
);
    localparam int PI_W = (MEMBERS > 1) ? $clog2(MEMBERS) : 1;
    localparam int QI_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = MEMBERS * QUEUE_DEPTH;
    localparam int MA_W = $clog2(MEM_DEPTH);

    typedef enum logic [3:0] {
        ST_SWEEP, ST_IDLE, ST_EXEC, ST_DATA2, ST_ACKCHK, ST_RDWAIT,
        ST_REL, ST_OUT
    } state_t;

    logic [AMOUNT_W-1:0] init_window_reg, ack_thresh_reg;
    logic [OVH_W-1:0]    overhead_reg;

    logic signed [CREDIT_W-1:0] send_credit_reg [MEMBERS];
    logic signed [CREDIT_W-1:0] recv_credit_reg [MEMBERS];
    logic [MEMBERS-1:0]         failed_reg;
    logic [QI_W-1:0]            head_reg [MEMBERS];
    logic [QC_W-1:0]            count_reg [MEMBERS];

    logic [TAG_W+AMOUNT_W-1:0] held_mem [MEM_DEPTH];
    logic [TAG_W+AMOUNT_W-1:0] held_rd_reg;

    state_t state_reg;
    state_t ret_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [PEER_W-1:0]   peer_reg;
    logic [AMOUNT_W-1:0] amount_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic [PI_W-1:0]     sweep_reg;
    logic                sweep_fail_reg;
    logic [4:0]          nres_reg;
    logic signed [CREDIT_W-1:0] acc_reg;
    result_t             out_reg;
    logic                out_valid_reg;

    // shared adder
    logic signed [CREDIT_W-1:0] add_a, add_sum;
    logic signed [CREDIT_W:0]   add_b;
    ppcfc_sat_add u_add (.a(add_a), .b(add_b), .sum(add_sum));

    logic [PI_W-1:0] pidx;
    logic            peer_ok;
    logic signed [CREDIT_W:0] cost;
    logic [QI_W:0]   slot_sum;
    logic [QI_W-1:0] slot, head_nx;
    logic [MA_W-1:0] wr_addr, rd_addr;

    always_comb begin
        pidx    = PI_W'(peer_reg);
        peer_ok = 32'(peer_reg) < MEMBERS;
        cost    = (CREDIT_W+1)'(amount_reg) + (CREDIT_W+1)'(overhead_reg);
        slot_sum = (QI_W+1)'(head_reg[pidx]) + (QI_W+1)'(count_reg[pidx]);
        slot = (slot_sum >= (QI_W+1)'(QUEUE_DEPTH))
            ? QI_W'(slot_sum - (QI_W+1)'(QUEUE_DEPTH)) : QI_W'(slot_sum);
        head_nx = (32'(head_reg[pidx]) == QUEUE_DEPTH - 1) ? '0
            : head_reg[pidx] + 1'b1;
        wr_addr = MA_W'(32'(pidx) * QUEUE_DEPTH + 32'(slot));
        rd_addr = MA_W'(32'(pidx) * QUEUE_DEPTH + 32'(head_reg[pidx]));
        add_a = send_credit_reg[pidx];
        add_b = -cost;
        unique case (state_reg)
            ST_EXEC: begin
                if (kind_reg == KIND_DATA) begin
                    add_a = recv_credit_reg[pidx];
                    add_b = cost;
                end else if (kind_reg == KIND_ACK) begin
                    add_b = (CREDIT_W+1)'(amount_reg);
                end
            end
            ST_DATA2: begin
                add_a = acc_reg;
                add_b = (acc_reg > 32'sd1048575) ? -(CREDIT_W+1)'(20'hfffff)
                                                 : -(CREDIT_W+1)'(acc_reg);
            end
            ST_REL: begin
                add_b = -((CREDIT_W+1)'(held_rd_reg[AMOUNT_W-1:0])
                          + (CREDIT_W+1)'(overhead_reg));
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.amount, out_reg.tag, out_reg.peer, out_reg.action};
    assign m_tlast  = out_reg.last;

    function automatic result_t mk(logic [ACT_W-1:0] a, logic [PEER_W-1:0] p,
                                   logic [TAG_W-1:0] t, logic [AMOUNT_W-1:0] m,
                                   logic l);
        result_t r;
        r.action = a; r.peer = p; r.tag = t; r.amount = m; r.last = l;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXEC && kind_reg == KIND_SEND && peer_ok
                && !failed_reg[pidx] && send_credit_reg[pidx] <= 0
                && 32'(count_reg[pidx]) < QUEUE_DEPTH) begin
            held_mem[wr_addr] <= {tag_reg, amount_reg};
        end
        held_rd_reg <= held_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_window_reg <= INIT_WINDOW_RST;
            ack_thresh_reg  <= ACK_THRESH_RST;
            overhead_reg    <= OVERHEAD_RST;
            state_reg       <= ST_SWEEP;
            ret_reg         <= ST_IDLE;
            sweep_reg       <= '0;
            sweep_fail_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            nres_reg        <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx)
                    REG_INIT_WINDOW: init_window_reg <= cfg_data;
                    REG_ACK_THRESH:  ack_thresh_reg  <= cfg_data;
                    REG_OVERHEAD:    overhead_reg    <= cfg_data[OVH_W-1:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_SWEEP: begin
                    if (!sweep_fail_reg || mask_reg[sweep_reg]) begin
                        send_credit_reg[sweep_reg] <= sweep_fail_reg ? '0
                            : CREDIT_W'(init_window_reg);
                        recv_credit_reg[sweep_reg] <= '0;
                        head_reg[sweep_reg]  <= '0;
                        count_reg[sweep_reg] <= '0;
                    end
                    failed_reg[sweep_reg] <= sweep_fail_reg
                        && (32'(sweep_reg) < MASK_W) && mask_reg[sweep_reg];
                    if (32'(sweep_reg) == MEMBERS - 1) begin
                        sweep_reg <= '0;
                        if (ret_reg == ST_OUT) begin
                            out_reg <= mk(ACT_DONE, '0, '0, '0, 1'b1);
                            out_valid_reg <= 1'b1;
                        end
                        state_reg <= ret_reg;
                    end else begin
                        sweep_reg <= sweep_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg   <= s_tdata[2:0];
                        peer_reg   <= s_tdata[6:3];
                        amount_reg <= s_tdata[26:7];
                        tag_reg    <= s_tdata[42:27];
                        mask_reg   <= s_tdata[58:43];
                        nres_reg   <= '0;
                        state_reg  <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (kind_reg <= KIND_ACK && !peer_ok) begin
                        out_reg <= (kind_reg == KIND_SEND)
                            ? mk(ACT_DROP, peer_reg, tag_reg, amount_reg, 1'b1)
                            : mk(ACT_DONE, peer_reg, '0, '0, 1'b1);
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_OUT;
                    end else if (kind_reg == KIND_SEND) begin
                        if (failed_reg[pidx]) begin
                            out_reg <= mk(ACT_DROP, peer_reg, tag_reg, amount_reg, 1'b1);
                        end else if (send_credit_reg[pidx] > 0) begin
                            send_credit_reg[pidx] <= add_sum;
                            out_reg <= mk(ACT_SEND, peer_reg, tag_reg, amount_reg, 1'b1);
                        end else if (32'(count_reg[pidx]) >= QUEUE_DEPTH) begin
                            out_reg <= mk(ACT_DROP, peer_reg, tag_reg, amount_reg, 1'b1);
                        end else begin
                            count_reg[pidx] <= count_reg[pidx] + 1'b1;
                            out_reg <= mk(ACT_QUEUED, peer_reg, tag_reg, amount_reg, 1'b1);
                        end
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_OUT;
                    end else if (kind_reg == KIND_DATA) begin
                        acc_reg <= add_sum;
                        state_reg <= ST_DATA2;
                    end else if (kind_reg == KIND_ACK) begin
                        send_credit_reg[pidx] <= add_sum;
                        state_reg <= ST_ACKCHK;
                    end else if (kind_reg == KIND_FAIL || kind_reg == KIND_REINIT) begin
                        sweep_fail_reg <= (kind_reg == KIND_FAIL);
                        ret_reg <= ST_OUT;
                        state_reg <= ST_SWEEP;
                    end else begin
                        out_reg <= mk(ACT_DONE, peer_reg, '0, '0, 1'b1);
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                end
                ST_DATA2: begin
                    if (acc_reg > $signed({12'd0, ack_thresh_reg})) begin
                        recv_credit_reg[pidx] <= add_sum;
                        out_reg <= mk(ACT_ACK, peer_reg, '0,
                            (acc_reg > 32'sd1048575) ? 20'hfffff : acc_reg[AMOUNT_W-1:0],
                            1'b0);
                        ret_reg <= ST_DATA2;
                        acc_reg <= 32'sd0;
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_OUT;
                        kind_reg <= KIND_REINIT;
                    end else begin
                        if (kind_reg != KIND_REINIT) begin
                            recv_credit_reg[pidx] <= acc_reg;
                        end
                        out_reg <= mk(ACT_DELIVER, peer_reg, tag_reg, amount_reg, 1'b1);
                        ret_reg <= ST_IDLE;
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                end
                ST_ACKCHK: begin
                    if (nres_reg < 5'(MAX_RESULTS) && send_credit_reg[pidx] > 0
                            && count_reg[pidx] != '0) begin
                        state_reg <= ST_RDWAIT;
                    end else if (nres_reg == '0) begin
                        out_reg <= mk(ACT_DONE, peer_reg, '0, '0, 1'b1);
                        out_valid_reg <= 1'b1;
                        ret_reg <= ST_IDLE;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RDWAIT: state_reg <= ST_REL;
                ST_REL: begin
                    send_credit_reg[pidx] <= add_sum;
                    head_reg[pidx]  <= head_nx;
                    count_reg[pidx] <= count_reg[pidx] - 1'b1;
                    nres_reg <= nres_reg + 1'b1;
                    out_reg <= mk(ACT_RELEASE, peer_reg, held_rd_reg[TAG_W+AMOUNT_W-1:AMOUNT_W],
                        held_rd_reg[AMOUNT_W-1:0],
                        (nres_reg + 1'b1 == 5'(MAX_RESULTS)) || add_sum <= 0
                        || count_reg[pidx] == QC_W'(1));
                    out_valid_reg <= 1'b1;
                    ret_reg <= ST_ACKCHK;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_tready) begin
                        out_valid_reg <= 1'b0;
                        state_reg <= out_reg.last ? ST_IDLE : ret_reg;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accepted input while result pending");
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("ready after accept");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result changed while stalled");
`endif
endmodule

### tb/per_peer_credit_flow_control_test.sv
// Testbench for per_peer_credit_flow_control: directed and random streams of
// sends, data, acks, failures, reinits and unknown kinds, checked against a
// credit predictor. Depends on ppcfc_pkg and the block's RTL.
module per_peer_credit_flow_control_test
    import ppcfc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPEER = 16;
    localparam int QDEPTH = 16;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [PEER_W-1:0]   peer;
        logic [AMOUNT_W-1:0] amount;
        logic [TAG_W-1:0]    tag;
        logic [MASK_W-1:0]   mask;
    } req_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [63:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [47:0] m_tdata;
    logic m_tlast;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [AMOUNT_W-1:0] cfg_data = '0;

    per_peer_credit_flow_control dut (.*);

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    // predictor state
    logic [AMOUNT_W-1:0] win_q, thr_q;
    logic [OVH_W-1:0] ovh_q;
    longint send_cr[NPEER], recv_cr[NPEER];
    bit failed[NPEER];
    logic [TAG_W-1:0] held_tag[NPEER][QDEPTH];
    logic [AMOUNT_W-1:0] held_len[NPEER][QDEPTH];
    int head[NPEER], cnt[NPEER];

    result_t expected_q[$];
    req_t pending_q[$];
    int errors = 0;
    longint cycles = 0;
    bit calm = 0;
    bit s_tready_seen = 0;
    bit hold = 1;

    function automatic longint sat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void clear_tables();
        for (int i = 0; i < NPEER; i++) begin
            send_cr[i] = win_q;
            recv_cr[i] = 0;
            failed[i] = 0;
            head[i] = 0;
            cnt[i] = 0;
        end
    endfunction

    function automatic void push(logic [ACT_W-1:0] a, int p, logic [TAG_W-1:0] t,
                                 logic [AMOUNT_W-1:0] amt);
        result_t r;
        r.action = a;
        r.peer = p[PEER_W-1:0];
        r.tag = t;
        r.amount = amt;
        r.last = 0;
        expected_q.push_back(r);
    endfunction

    function automatic void predict_credit(req_t q);
        int p;
        int n0;
        longint cost;
        longint rc;
        longint carry;
        p = q.peer;
        n0 = expected_q.size();
        cost = longint'(q.amount) + longint'(ovh_q);
        case (q.kind)
            KIND_SEND: begin
                if (failed[p]) push(ACT_DROP, p, q.tag, q.amount);
                else if (send_cr[p] > 0) begin
                    send_cr[p] = sat(send_cr[p] - cost);
                    push(ACT_SEND, p, q.tag, q.amount);
                end else if (cnt[p] >= QDEPTH) push(ACT_DROP, p, q.tag, q.amount);
                else begin
                    held_tag[p][(head[p] + cnt[p]) % QDEPTH] = q.tag;
                    held_len[p][(head[p] + cnt[p]) % QDEPTH] = q.amount;
                    cnt[p]++;
                    push(ACT_QUEUED, p, q.tag, q.amount);
                end
            end
            KIND_DATA: begin
                rc = sat(recv_cr[p] + cost);
                if (rc > longint'(thr_q)) begin
                    carry = rc > 1048575 ? 1048575 : rc;
                    rc = sat(rc - carry);
                    push(ACT_ACK, p, '0, carry[AMOUNT_W-1:0]);
                end
                recv_cr[p] = rc;
                push(ACT_DELIVER, p, q.tag, q.amount);
            end
            KIND_ACK: begin
                send_cr[p] = sat(send_cr[p] + longint'(q.amount));
                while (expected_q.size() - n0 < MAX_RESULTS && send_cr[p] > 0
                       && cnt[p] > 0) begin
                    push(ACT_RELEASE, p, held_tag[p][head[p]], held_len[p][head[p]]);
                    send_cr[p] = sat(send_cr[p] - longint'(held_len[p][head[p]])
                                     - longint'(ovh_q));
                    head[p] = (head[p] + 1) % QDEPTH;
                    cnt[p]--;
                end
                if (expected_q.size() == n0) push(ACT_DONE, p, '0, '0);
            end
            KIND_FAIL: begin
                for (int i = 0; i < NPEER; i++) begin
                    failed[i] = q.mask[i];
                    if (q.mask[i]) begin
                        head[i] = 0;
                        cnt[i] = 0;
                        send_cr[i] = 0;
                        recv_cr[i] = 0;
                    end
                end
                push(ACT_DONE, 0, '0, '0);
            end
            KIND_REINIT: begin
                clear_tables();
                push(ACT_DONE, 0, '0, '0);
            end
            default: push(ACT_DONE, p, '0, '0);
        endcase
        expected_q[$].last = 1;
    endfunction

    // driver
    int s_gap = 0;
    always @(negedge aclk) begin
        req_t q;
        if (s_tvalid && s_tready_seen) begin
            void'(pending_q.pop_front());
        end
        if (s_gap > 0) begin
            s_gap--;
            s_tvalid <= 0;
        end else if (!calm && !(s_tvalid && !s_tready_seen) && $urandom_range(0, 7) == 0) begin
            s_gap = $urandom_range(1, 9) - 1;
            s_tvalid <= 0;
        end else if (pending_q.size() > 0 && !hold) begin
            q = pending_q[0];
            s_tdata <= {5'b0, q.mask, q.tag, q.amount, q.peer, q.kind};
            s_tvalid <= 1;
        end else s_tvalid <= 0;
    end

    always @(posedge aclk) begin
        s_tready_seen <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            predict_credit(req_t'({s_tdata[2:0], s_tdata[6:3], s_tdata[26:7],
                                   s_tdata[42:27], s_tdata[58:43]}));
        end
    end

    // monitor
    int m_gap = 0;
    always @(negedge aclk) begin
        if (m_gap > 0) begin
            m_gap--;
            m_tready <= 0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            m_gap = $urandom_range(1, 9) - 1;
            m_tready <= 0;
        end else m_tready <= 1;
    end

    always @(posedge aclk) begin
        result_t r, e;
        cycles++;
        if (aresetn && m_tvalid && m_tready) begin
            r.action = m_tdata[2:0];
            r.peer = m_tdata[6:3];
            r.tag = m_tdata[22:7];
            r.amount = m_tdata[42:23];
            r.last = m_tlast;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result: actual %h", $realtime, r);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (r !== e) begin
                    $display("%0t mismatch: expected %h actual %h", $realtime, e, r);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [AMOUNT_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 0;
        case (idx)
            REG_INIT_WINDOW: win_q = val;
            REG_ACK_THRESH:  thr_q = val;
            default:         ovh_q = val[OVH_W-1:0];
        endcase
    endtask

    task automatic add(logic [KIND_W-1:0] k, int p, logic [AMOUNT_W-1:0] a,
                       logic [TAG_W-1:0] t, logic [MASK_W-1:0] m);
        req_t q;
        q.kind = k;
        q.peer = p[PEER_W-1:0];
        q.amount = a;
        q.tag = t;
        q.mask = m;
        pending_q.push_back(q);
    endtask

    task automatic drain();
        hold = 0;
        while (pending_q.size() > 0 || s_tvalid || expected_q.size() > 0) @(posedge aclk);
        hold = 1;
        repeat (60) @(posedge aclk);
    endtask

    task automatic random_items(int n, int hot);
        int k, p;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            p = $urandom_range(0, hot);
            if (k < 40) add(KIND_SEND, p, AMOUNT_W'($urandom_range(0, 3) == 0 ? $urandom
                            : $urandom_range(0, 70000)), TAG_W'($urandom),
                            MASK_W'($urandom));
            else if (k < 62) add(KIND_DATA, p, AMOUNT_W'($urandom_range(0, 1) ? $urandom
                                 : $urandom_range(0, 40000)), TAG_W'($urandom),
                                 MASK_W'($urandom));
            else if (k < 87) add(KIND_ACK, p, AMOUNT_W'($urandom_range(0, 2) == 0 ? $urandom
                                 : $urandom_range(0, 200000)), TAG_W'($urandom),
                                 MASK_W'($urandom));
            else if (k < 92) add(KIND_FAIL, p, AMOUNT_W'($urandom), TAG_W'($urandom),
                                 MASK_W'($urandom_range(0, 1) ? ($urandom & 16'h0101)
                                         : $urandom));
            else if (k < 95) add(KIND_REINIT, p, AMOUNT_W'($urandom), TAG_W'($urandom),
                                 MASK_W'($urandom));
            else add(KIND_W'($urandom_range(5, 7)), p, AMOUNT_W'($urandom),
                     TAG_W'($urandom), MASK_W'($urandom));
        end
    endtask

    initial begin
        win_q = INIT_WINDOW_RST;
        thr_q = ACK_THRESH_RST;
        ovh_q = OVERHEAD_RST;
        clear_tables();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: drive peer 0 negative, fill and overflow its queue, drain
        add(KIND_SEND, 0, 20'hFFFFF, 16'hFFFF, 16'hFFFF);
        add(KIND_SEND, 0, 0, 16'h0000, 0);
        for (int i = 0; i < 17; i++) add(KIND_SEND, 0, AMOUNT_W'(i), TAG_W'(16'h1000 + i), 0);
        add(KIND_ACK, 0, 20'hFFFFF, 0, 0);
        add(KIND_ACK, 0, 0, 0, 0);
        add(KIND_DATA, 15, 20'hFFFFF, 16'hABCD, 0);
        add(KIND_DATA, 3, 0, 16'h5555, 0);
        add(KIND_FAIL, 0, 0, 0, 16'h8001);
        add(KIND_SEND, 15, 5, 16'h2222, 0);
        add(KIND_DATA, 15, 5, 16'h3333, 0);
        add(3'd7, 9, 1, 1, 1);
        add(KIND_REINIT, 0, 0, 0, 0);
        drain();

        write_reg(REG_INIT_WINDOW, 0);
        write_reg(REG_ACK_THRESH, 0);
        write_reg(REG_OVERHEAD, 12'hFFF);
        add(KIND_REINIT, 0, 0, 0, 0);
        random_items(70, 3);
        drain();

        write_reg(REG_INIT_WINDOW, 20'hFFFFF);
        write_reg(REG_ACK_THRESH, 20'hFFFFF);
        write_reg(REG_OVERHEAD, 0);
        add(KIND_REINIT, 0, 0, 0, 0);
        random_items(70, 15);
        drain();

        write_reg(REG_INIT_WINDOW, 5000);
        write_reg(REG_ACK_THRESH, 30000);
        write_reg(REG_OVERHEAD, 64);
        add(KIND_REINIT, 0, 0, 0, 0);
        random_items(40, 2);
        hold = 0;
        while (pending_q.size() > 20) @(posedge aclk);
        calm = 1;
        drain();

        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        wait (cycles > 400000);
        $display("status: fail");
        $finish;
    end
endmodule

### per_peer_credit_flow_control.f
src/ppcfc_pkg.sv
src/ppcfc_sat_add.sv
src/per_peer_credit_flow_control.sv
tb/per_peer_credit_flow_control_test.sv
